// File: rtl/asoa_pkg.sv
// ----------------------------------------------------------------------------
// asoa_pkg
// Shared types and constants of the oversampling averager: payload structs,
// status codes, register indexes, and controller/datapath command records.
// ----------------------------------------------------------------------------
package asoa_pkg;

    // Field widths
    localparam int CODE_BITS_DEF = 12;
    localparam int COUNT_W       = 16;
    localparam int VREF_W        = 13;
    localparam int CHANS_W       = 4;
    localparam int CHAN_W        = 3;
    localparam int FRAME_W       = 24;
    localparam int AVG_W         = 12;
    localparam int MV_W          = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 1;

    // Register reset values
    localparam logic [VREF_W-1:0]  VREF_RESET  = 13'd3300;
    localparam logic [CHANS_W-1:0] CHANS_RESET = 4'd8;

    // Leading bits of the command frame: five zeros, then the start bit
    localparam logic [5:0] CMD_START_BITS = 6'b000001;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VREF  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANS = 1'b1;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CHANNEL = 2'd1,
        ST_ZERO_COUNT  = 2'd2
    } t_status;

    typedef struct packed {
        logic                req_type;
        logic [CHAN_W-1:0]   channel;
        logic                single_ended;
        logic [COUNT_W-1:0]  conv_count;
        logic [FRAME_W-1:0]  rx_frame;
    } t_in_item;

    typedef struct packed {
        logic                is_result;
        t_status             status;
        logic [FRAME_W-1:0]  command_frame;
        logic [AVG_W-1:0]    avg_code;
        logic [MV_W-1:0]     millivolts;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic start;       // answer a start request, begin collecting if valid
        logic frame;       // add one code to the accumulator
        logic div_init;    // load divider from accumulator
        logic div_step;    // one restoring division step
        logic mul;         // scale the mean by the reference voltage
        logic out_result;  // load the averaged result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic collecting;
        logic last_frame;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/asoa_ctrl.sv
// ----------------------------------------------------------------------------
// asoa_ctrl
// Controller: input handshake, sequencing of the final division, scaling and
// result hand-off.
// ----------------------------------------------------------------------------
module asoa_ctrl
    import asoa_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_req_type,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    localparam int CNT_W = $clog2(CODE_BITS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DINIT = 5'b00010,
        S_DIV   = 5'b00100,
        S_MUL   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              needs_out;
    logic              accept;

    // Stall while busy, or when the item would answer into a full output
    assign needs_out  = (i_req_type == REQ_START) ||
                        (i_sts.collecting && i_sts.last_frame);
    assign o_in_stall = (r_state != S_IDLE) || (needs_out && !i_sts.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req_type == REQ_START) begin
                    o_cmd.start = 1'b1;
                end else if (accept && i_sts.collecting) begin
                    o_cmd.frame = 1'b1;
                    if (i_sts.last_frame) begin
                        n_state = S_DINIT;
                    end
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = CNT_W'(CODE_BITS - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_result = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: rtl/asoa_dp.sv
// ----------------------------------------------------------------------------
// asoa_dp
// Datapath: configuration registers, accumulator and frame counters, a
// bit-serial restoring divider, the millivolt multiplier and the output
// register.
// ----------------------------------------------------------------------------
module asoa_dp
    import asoa_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);

    localparam int ACC_W  = CODE_BITS + COUNT_W;
    localparam int PROD_W = CODE_BITS + VREF_W;

    logic [VREF_W-1:0]    r_vref, n_vref;
    logic [CHANS_W-1:0]   r_chans, n_chans;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [COUNT_W-1:0]   r_left, n_left;
    logic [COUNT_W-1:0]   r_total, n_total;
    logic                 r_collecting, n_collecting;
    logic [COUNT_W-1:0]   r_rem, n_rem;
    logic [CODE_BITS-1:0] r_quo, n_quo;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 ch_bad;
    logic                 cnt_zero;
    logic [COUNT_W:0]     trial;
    logic                 fits;
    logic [CODE_BITS-1:0] code;

    // Start request checks, channel before count
    assign ch_bad   = {1'b0, i_in_data.channel} >= r_chans;
    assign cnt_zero = (i_in_data.conv_count == '0);
    assign code     = i_in_data.rx_frame[CODE_BITS-1:0];

    // Restoring division step: shift in next dividend bit, trial subtract
    assign trial = {r_rem, r_quo[CODE_BITS-1]};
    assign fits  = (trial >= {1'b0, r_total});

    assign o_sts.collecting = r_collecting;
    assign o_sts.last_frame = (r_left == COUNT_W'(1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_vref       = r_vref;
        n_chans      = r_chans;
        n_acc        = r_acc;
        n_left       = r_left;
        n_total      = r_total;
        n_collecting = r_collecting;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;

        // Register writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VREF:  n_vref  = i_cfg_data[VREF_W-1:0];
                CFG_CHANS: n_chans = i_cfg_data[CHANS_W-1:0];
                default:   n_vref  = r_vref;
            endcase
        end

        // Answer a start request; only a valid one restarts collection
        if (i_cmd.start) begin
            n_out       = '0;
            n_out_valid = 1'b1;
            priority if (ch_bad) begin
                n_out.status = ST_BAD_CHANNEL;
            end else if (cnt_zero) begin
                n_out.status = ST_ZERO_COUNT;
            end else begin
                n_out.status        = ST_OK;
                n_out.command_frame = {CMD_START_BITS, i_in_data.single_ended,
                                       i_in_data.channel, 6'b000000, 8'h00};
                n_acc               = '0;
                n_left              = i_in_data.conv_count;
                n_total             = i_in_data.conv_count;
                n_collecting        = 1'b1;
            end
        end

        // Accumulate one code
        if (i_cmd.frame) begin
            n_acc  = r_acc + ACC_W'(code);
            n_left = r_left - 1'b1;
            if (r_left == COUNT_W'(1)) begin
                n_collecting = 1'b0;
            end
        end

        // Upper part of the sum is below the count, so the quotient
        // fits in CODE_BITS bits
        if (i_cmd.div_init) begin
            n_rem = r_acc[ACC_W-1:CODE_BITS];
            n_quo = r_acc[CODE_BITS-1:0];
        end

        if (i_cmd.div_step) begin
            n_rem = fits ? COUNT_W'(trial - {1'b0, r_total}) : trial[COUNT_W-1:0];
            n_quo = {r_quo[CODE_BITS-2:0], fits};
        end

        if (i_cmd.mul) begin
            n_prod = PROD_W'(r_quo) * PROD_W'(r_vref);
        end

        if (i_cmd.out_result) begin
            n_out            = '0;
            n_out.is_result  = 1'b1;
            n_out.status     = ST_OK;
            n_out.avg_code   = AVG_W'(r_quo);
            n_out.millivolts = r_prod[CODE_BITS +: MV_W];
            n_out_valid      = 1'b1;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref       <= VREF_RESET;
            r_chans      <= CHANS_RESET;
            r_acc        <= '0;
            r_left       <= '0;
            r_total      <= '0;
            r_collecting <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_vref       <= n_vref;
            r_chans      <= n_chans;
            r_acc        <= n_acc;
            r_left       <= n_left;
            r_total      <= n_total;
            r_collecting <= n_collecting;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

endmodule

// File: rtl/adc_spi_oversample_averager.sv
// ----------------------------------------------------------------------------
// adc_spi_oversample_averager
// Oversampling averager for a SPI converter: answers start requests with the
// command frame, sums received codes and reports mean code and millivolts.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_data   (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_data  (t_out_item)
//  cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  Start requests and non-final frames leave the controller idle, ready for
//  the next item. The final frame runs through accept, divider load, one
//  restoring division step per mean bit, multiply and output load; the
//  bit-serial divider makes this the longest sequence.
//  Reset clears the controller, counters, accumulator and output valid, and
//  restores vref_mv 3300 and channels_available 8.
//  The input stalls only from divider load to output load of a final frame,
//  or when an item that answers finds the output register full and stalled.
// ----------------------------------------------------------------------------
module adc_spi_oversample_averager
    import asoa_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    asoa_ctrl #(
        .CODE_BITS (CODE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage
    asoa_dp #(
        .CODE_BITS (CODE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/asoa_checker.sv
// ----------------------------------------------------------------------------
// asoa_checker
// Port-level checks of the averager: output hold under stall, answer
// timing and field contents of each result kind.
// ----------------------------------------------------------------------------
module asoa_checker
    import asoa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input t_in_item  i_in_data,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // Answer every accepted start transaction on the next cycle
    a_start_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && i_in_data.req_type == REQ_START
        |=> i_out_valid && !i_out_data.is_result)
        else $error("start transaction not answered");

    // Averaged results carry status OK and no command frame
    a_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.is_result
        |-> i_out_data.status == ST_OK && i_out_data.command_frame == '0)
        else $error("averaged result carries start fields");

    // Error answers are empty apart from the status
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.is_result && i_out_data.status != ST_OK
        |-> i_out_data.command_frame == '0 && i_out_data.avg_code == '0
            && i_out_data.millivolts == '0)
        else $error("error answer has data fields set");

    // Good start answers hold a command frame and no measurement
    a_start_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.is_result && i_out_data.status == ST_OK
        |-> i_out_data.command_frame[23:18] == CMD_START_BITS
            && i_out_data.avg_code == '0 && i_out_data.millivolts == '0)
        else $error("malformed start answer");

endmodule

bind adc_spi_oversample_averager asoa_checker u_asoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the oversampling averager. A built-in predictor
// tracks the collection state and the registers and works out the answer to
// each accepted request. Directed tests cover the status codes, the frame
// layout and the register extremes. Random phases then run start/frame
// sequences with noise, while the sender pauses in bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
    import asoa_pkg::*;

    localparam int CODE_BITS   = CODE_BITS_DEF;
    localparam int SETTLE      = CODE_BITS + 8;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 140;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_VREF;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;

    // Predictor copy of the registers and the collection state
    logic [VREF_W-1:0]  vref_mv      = VREF_RESET;
    logic [CHANS_W-1:0] chans_avail  = CHANS_RESET;
    logic [27:0]        code_sum     = '0;
    logic [COUNT_W-1:0] frames_left  = '0;
    logic [COUNT_W-1:0] frames_total = '0;
    logic               collecting   = 1'b0;

    t_out_item pending_answers[$];
    int        errors     = 0;
    int        burst_left = 0;
    int        stall_mode = 0;
    int        stall_left = 0;

    adc_spi_oversample_averager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Work out the answer to one accepted request; return 1 if there is one
    function automatic bit compute_answer(input t_in_item item, output t_out_item ans);
        logic [27:0] mean;
        logic [40:0] scaled;
        ans = '0;
        if (item.req_type == REQ_START) begin
            // Check the channel before the count
            if ({1'b0, item.channel} >= chans_avail) begin
                ans.status = ST_BAD_CHANNEL;
                return 1'b1;
            end
            if (item.conv_count == '0) begin
                ans.status = ST_ZERO_COUNT;
                return 1'b1;
            end
            ans.status        = ST_OK;
            ans.command_frame = {5'b00000, 1'b1, item.single_ended, item.channel,
                                 6'b000000, 8'h00};
            code_sum     = '0;
            frames_left  = item.conv_count;
            frames_total = item.conv_count;
            collecting   = 1'b1;
            return 1'b1;
        end
        // Drop frames while idle
        if (!collecting)
            return 1'b0;
        code_sum    = code_sum + item.rx_frame[CODE_BITS-1:0];
        frames_left = frames_left - 1'b1;
        if (frames_left != '0)
            return 1'b0;
        collecting      = 1'b0;
        mean            = code_sum / frames_total;
        scaled          = mean * vref_mv;
        ans.is_result   = 1'b1;
        ans.status      = ST_OK;
        ans.avg_code    = mean[AVG_W-1:0];
        ans.millivolts  = MV_W'(scaled >> CODE_BITS);
        return 1'b1;
    endfunction

    function automatic t_in_item make_start(input int chan, input int sgl, input int count);
        logic [63:0] noise;
        t_in_item    item;
        noise              = {$urandom, $urandom};
        item               = noise[$bits(t_in_item)-1:0];
        item.req_type      = REQ_START;
        item.channel       = CHAN_W'(chan);
        item.single_ended  = sgl[0];
        item.conv_count    = COUNT_W'(count);
        return item;
    endfunction

    function automatic t_in_item make_frame(input logic [FRAME_W-1:0] rx);
        logic [63:0] noise;
        t_in_item    item;
        noise         = {$urandom, $urandom};
        item          = noise[$bits(t_in_item)-1:0];
        item.req_type = REQ_FRAME;
        item.rx_frame = rx;
        return item;
    endfunction

    // Frame with random upper bits and a code that often sits at an extreme
    function automatic logic [FRAME_W-1:0] random_frame();
        logic [FRAME_W-1:0] rx;
        rx = FRAME_W'($urandom);
        case ($urandom_range(0, 5))
            0: rx[CODE_BITS-1:0] = '1;
            1: rx[CODE_BITS-1:0] = '0;
            default: ;
        endcase
        return rx;
    endfunction

    // Start request that must be refused
    function automatic t_in_item refused_start();
        if (chans_avail < 8 && $urandom_range(0, 1) == 1)
            return make_start($urandom_range(chans_avail, 7), $urandom_range(0, 1),
                              $urandom_range(0, 65535));
        return make_start($urandom_range(0, chans_avail - 1), $urandom_range(0, 1), 0);
    endfunction

    // Send one transaction and predict its answer
    task automatic send_item(input t_in_item item);
        t_out_item ans;
        int        gap;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        if (compute_answer(item, ans))
            pending_answers.push_back(ans);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold the input idle until every answer is in and the divider is done
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Finish an open collection with a one-frame run
    task automatic close_collection();
        if (collecting) begin
            send_item(make_start(0, $urandom_range(0, 1), 1));
            send_item(make_frame(random_frame()));
        end
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input int vref, input int chans);
        close_collection();
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VREF;
        cfg_data  <= CFG_DATA_W'(vref);
        @(posedge i_clk);
        vref_mv    = VREF_W'(vref);
        cfg_index <= CFG_CHANS;
        cfg_data  <= CFG_DATA_W'(chans);
        @(posedge i_clk);
        chans_avail = CHANS_W'(chans);
        cfg_we     <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reset register values, full code with upper frame bits set
    task automatic test_reset_values();
        send_item(make_start(7, 1, 1));
        send_item(make_frame(24'hFFFFFF));
    endtask

    // Refused starts, count extremes, restart and refused start mid-run
    task automatic test_start_checks();
        set_config(3300, 4);
        send_item(make_start(4, 0, 5));
        send_item(make_start(7, 1, 0));
        send_item(make_start(3, 1, 0));
        send_item(make_start(0, 0, 65535));
        send_item(make_frame(24'h000123));
        send_item(make_start(3, 1, 2));
        send_item(make_frame(24'h000FFF));
        send_item(make_start(5, 0, 3));
        send_item(make_frame(24'hFFF000));
    endtask

    // Frames while idle give nothing
    task automatic test_idle_frames();
        set_config(3300, 8);
        send_item(make_frame(24'h123FFF));
        send_item(make_frame(24'h000000));
        send_item(make_start(1, 0, 3));
        send_item(make_frame(24'h000001));
        send_item(make_frame(24'h800002));
        send_item(make_frame(24'h000004));
    endtask

    // Scaling at the lowest and highest reference voltage
    task automatic test_vref_extremes();
        set_config(250, 8);
        send_item(make_start(6, 1, 1));
        send_item(make_frame(24'hABCFFF));
        set_config(7000, 8);
        send_item(make_start(2, 0, 3));
        send_item(make_frame(24'h000FFF));
        send_item(make_frame(24'hFFFFFF));
        send_item(make_frame(24'h5A5FFE));
    endtask

    // Random phases: mostly full runs, some cut short, with noise mixed in
    task automatic test_random_traffic();
        int sent;
        int count;
        int span;
        int pick;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_config(7000, 8);
                1: set_config(250, 4);
                default: set_config($urandom_range(250, 7000), $urandom_range(4, 8));
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 14)
                        count = $urandom_range(1, 4);
                    else if (pick < 19)
                        count = $urandom_range(5, 48);
                    else
                        count = $urandom_range(1, 65535);
                    send_item(make_start($urandom_range(0, chans_avail - 1),
                                         $urandom_range(0, 1), count));
                    sent++;
                    // Cut long runs short; the next start drops them
                    span = (count > 48) ? $urandom_range(0, 12) : count;
                    if ($urandom_range(0, 9) == 0)
                        span = $urandom_range(0, span);
                    for (int i = 0; i < span; i++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_item(refused_start());
                            sent++;
                        end
                        send_item(make_frame(random_frame()));
                        sent++;
                    end
                end else begin
                    case ($urandom_range(0, 2))
                        0: begin
                            count = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
                            send_item(make_start($urandom_range(0, 7), $urandom_range(0, 1),
                                                 count));
                            sent++;
                        end
                        1: begin
                            if (collecting)
                                sent++;
                            send_item(make_frame(FRAME_W'($urandom)));
                        end
                        default: begin
                            send_item(refused_start());
                            sent++;
                        end
                    endcase
                end
            end
        end
        close_collection();
    endtask

    // Format the fields of one result
    function automatic string show(input t_out_item it);
        return $sformatf("res=%0d st=%0d cmd=%h avg=%0d mv=%0d", it.is_result,
                         it.status, it.command_frame, it.avg_code, it.millivolts);
    endfunction

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        errors++;
        if (errors <= 10)
            $display("%s: expected %s, got %s", what, show(want), show(got));
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_answers.size() == 0) begin
                note_mismatch("unexpected result", '0, out_data);
            end else begin
                want = pending_answers.pop_front();
                if (out_data.is_result !== want.is_result ||
                    out_data.status !== want.status ||
                    out_data.command_frame !== want.command_frame ||
                    out_data.avg_code !== want.avg_code ||
                    out_data.millivolts !== want.millivolts)
                    note_mismatch("result mismatch", want, out_data);
            end
        end
    end

    // Receiver stall pattern: free, light, even and heavy stretches
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_start_checks();
        test_idle_frames();
        test_vref_extremes();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/asoa_pkg.sv
rtl/asoa_ctrl.sv
rtl/asoa_dp.sv
rtl/adc_spi_oversample_averager.sv
rtl/asoa_checker.sv
test/testbench.sv
